// ----- rtl/mt_pkg.sv -----
// Shared constants and types for the MT19937 generator.
package mt_pkg;

	localparam int unsigned STATE_WORDS = 624;
	localparam int unsigned MIDDLE_OFS  = 397;
	localparam int unsigned IDX_W       = $clog2(STATE_WORDS);

	localparam logic [31:0] MATRIX_A  = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;
	localparam logic [31:0] INIT_MULT = 32'h6C07_8965;

	localparam int unsigned SHIFT_U = 11;
	localparam int unsigned SHIFT_S = 7;
	localparam int unsigned SHIFT_T = 15;
	localparam int unsigned SHIFT_L = 18;
	localparam int unsigned SHIFT_I = 30;

	localparam logic KIND_RESEED = 1'b0;
	localparam logic KIND_DRAW   = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [31:0]      word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_TW_PRE,
		ST_TWIST,
		ST_TW_DRAIN,
		ST_RD,
		ST_RD_DATA,
		ST_PUSH
	} mt_state_t;

endpackage

// ----- rtl/mt_req_if.sv -----
// Request channel: reseed or draw transaction.
interface mt_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] seed;

	modport source (output valid, output kind, output seed, input ready);
	modport sink (input valid, input kind, input seed, output ready);
endinterface

// ----- rtl/mt_rsp_if.sv -----
// Response channel: one tempered word per draw transaction.
interface mt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ----- rtl/mt_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module mt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

// ----- rtl/mt19937_random_generator_unit.sv -----
// MT19937 random generator top level: state memory, sequencer, tempering and output register.
//
// The 624-word twist state lives in one dual-read, single-write RAM. A reseed transaction
// folds its 64-bit seed to 32 bits (XOR of the halves) and consists of the acceptance
// followed by one memory write per state word, the initialization multiply being
// registered between words. A draw transaction passes from acceptance through memory
// read, read data and the load of the output register before the block is ready again;
// the load waits while the output register is held by a stalled sink. The first
// draw after a reseed, and every 624th draw after that one, first twists the whole state
// in place, one word per cycle through the single write port, with both source words of
// each step fetched a cycle ahead. Until the first reseed no memory is touched and every
// draw returns zero, going from acceptance straight to the output register load, so no
// clearing pass runs after reset. The output register holds a finished word while the
// next transaction is accepted.
module mt19937_random_generator_unit
	import mt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	mt_req_if.sink    req,
	mt_rsp_if.source  rsp
);

	// Standard output tempering.
	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> SHIFT_U);
		y = y ^ ((y << SHIFT_S) & TEMPER_B);
		y = y ^ ((y << SHIFT_T) & TEMPER_C);
		y = y ^ (y >> SHIFT_L);
		return y;
	endfunction

	localparam idx_t LAST_IDX = idx_t'(STATE_WORDS - 1);

	mt_state_t state_q, state_nx;

	idx_t              cnt_q;       // fill or twist step
	logic [IDX_W-1:0]  pos_q;       // read position, STATE_WORDS means exhausted
	logic              seeded_q;    // store holds seeded data
	word_t             wval_q;      // next word of the seed fill
	word_t             res_q;       // tempered word waiting for the output register
	word_t             cur_q;       // old value of the word being twisted
	logic              v_s1;
	logic              pre_s1;
	idx_t              idx_s1;
	logic              out_v_q;
	word_t             out_q;

	logic   mem_we;
	idx_t   mem_waddr;
	word_t  mem_wdata;
	idx_t   mem_ra;
	idx_t   mem_rb;
	word_t  mem_da;
	word_t  mem_db;

	logic   req_acc;
	logic   out_free;
	word_t  folded;
	word_t  fill_mix;
	word_t  fill_next;
	word_t  tw_y;
	word_t  tw_xa;
	idx_t   nxt_idx;
	idx_t   far_idx;
	logic [IDX_W:0] far_sum;

	mt_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_state_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_ra),
		.raddr_b (mem_rb),
		.rdata_a (mem_da),
		.rdata_b (mem_db)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;
	assign rsp.valid = out_v_q;
	assign rsp.value = out_q;

	assign folded = req.seed[63:32] ^ req.seed[31:0];

	// Initialization recurrence for the word after the one being written.
	assign fill_mix  = wval_q ^ (wval_q >> SHIFT_I);
	assign fill_next = word_t'(INIT_MULT * fill_mix) + word_t'(cnt_q) + 32'd1;

	// Twist step: upper bit of the current word, lower bits of the next one.
	assign tw_y  = {cur_q[31], mem_da[30:0]};
	assign tw_xa = (tw_y >> 1) ^ (tw_y[0] ? MATRIX_A : 32'd0);

	// Neighbor and far indices of the step being issued, wrapped around the store.
	assign nxt_idx = (cnt_q == LAST_IDX) ? '0 : cnt_q + idx_t'(1);
	assign far_sum = {1'b0, cnt_q} + (IDX_W+1)'(MIDDLE_OFS);
	assign far_idx = (far_sum >= (IDX_W+1)'(STATE_WORDS)) ?
		idx_t'(far_sum - (IDX_W+1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					if (req.kind == KIND_RESEED) begin
						state_nx = ST_SEED;
					end else if (!seeded_q) begin
						state_nx = ST_PUSH;
					end else if (pos_q == IDX_W'(STATE_WORDS)) begin
						state_nx = ST_TW_PRE;
					end else begin
						state_nx = ST_RD;
					end
				end
			end
			ST_SEED: begin
				if (cnt_q == LAST_IDX) begin
					state_nx = ST_IDLE;
				end
			end
			ST_TW_PRE:   state_nx = ST_TWIST;
			ST_TWIST: begin
				if (cnt_q == LAST_IDX) begin
					state_nx = ST_TW_DRAIN;
				end
			end
			ST_TW_DRAIN: state_nx = ST_RD;
			ST_RD:       state_nx = ST_RD_DATA;
			ST_RD_DATA:  state_nx = ST_PUSH;
			ST_PUSH: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default:     state_nx = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_db ^ tw_xa;
		mem_ra    = '0;
		mem_rb    = '0;
		case (state_q)
			ST_SEED: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = wval_q;
			end
			ST_TWIST: begin
				mem_ra = nxt_idx;
				mem_rb = far_idx;
				mem_we = v_s1 && !pre_s1;
			end
			ST_TW_DRAIN: begin
				mem_we = v_s1 && !pre_s1;
			end
			ST_RD: begin
				mem_ra = pos_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			pos_q    <= IDX_W'(STATE_WORDS);
			seeded_q <= 1'b0;
			v_s1     <= 1'b0;
			pre_s1   <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			v_s1    <= (state_q == ST_TW_PRE) || (state_q == ST_TWIST);
			pre_s1  <= (state_q == ST_TW_PRE);

			if (state_q == ST_SEED || state_q == ST_TWIST) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + idx_t'(1);
			end else begin
				cnt_q <= '0;
			end

			// Mark the store exhausted on reseed, rewind after a twist, advance per read.
			if (req_acc && req.kind == KIND_RESEED) begin
				pos_q    <= IDX_W'(STATE_WORDS);
				seeded_q <= 1'b1;
			end else if (state_q == ST_TW_DRAIN) begin
				pos_q <= '0;
			end else if (state_q == ST_RD_DATA) begin
				pos_q <= pos_q + IDX_W'(1);
			end

			if (state_q == ST_PUSH && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (v_s1) begin
			cur_q <= mem_da;
		end
		if (req_acc) begin
			wval_q <= folded;
		end else if (state_q == ST_SEED) begin
			wval_q <= fill_next;
		end
		if (req_acc) begin
			res_q <= '0;
		end else if (state_q == ST_RD_DATA) begin
			res_q <= temper(mem_da);
		end
		if (state_q == ST_PUSH && out_free) begin
			out_q <= res_q;
		end
	end

	// Checks.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("state memory written while idle");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= IDX_W'(STATE_WORDS))
		else $error("read position beyond the store");

	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (pos_q < IDX_W'(STATE_WORDS)) && seeded_q)
		else $error("read issued from an exhausted or unseeded store");

	a_reseed_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.kind == KIND_RESEED) |=> (state_q == ST_SEED) && (cnt_q == '0))
		else $error("reseed did not start the fill at word zero");

	a_seeded_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seeded_q))
		else $error("seeded flag dropped");

endmodule
